### rtl/wsr_pkg.sv
`timescale 1ns / 1ps

package wsr_pkg;

  localparam int DEF_WINDOW_ITEMS = 32;
  localparam int DEF_WINDOW_SLOTS = 1024;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ITEM   = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  localparam logic [1:0] ST_RANK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_PAST = 2'd2;

  localparam logic [10:0] WINDOW_COUNT_RESET = 11'd1;

endpackage

### rtl/wsr_ram.sv
`timescale 1ns / 1ps

module wsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/windowed_score_ranker.sv
// windowed_score_ranker: per-window descending rank of variant scores
// input beat: taken at a clock edge with start high and busy low; opcode picks
// a window end load, a variant item or a finish
// cfg_we / cfg_wdata write the number of window ends in use at any idle edge
// result beat: result_valid marks each result for exactly one cycle; last marks
// the final result of an input beat; the receiver cannot hold results off
// loads and items that join the open window are handled without leaving idle,
// and a full buffer gives its status result in the cycle after the beat
// an item that leaves the window scans the end table at one entry per cycle,
// then flushes the window: each buffered item is read and captured, and a
// valid one then sweeps all n buffered items, n the buffered count, one at a
// time through the single read port of the item buffer
// results are issued as the items are ranked; busy stays high until the last
// is issued
// reset closes the open window and sets the window count to one; the end
// table and item buffer keep their contents and need no clearing pass
`timescale 1ns / 1ps

module windowed_score_ranker #(
  parameter int WINDOW_ITEMS = wsr_pkg::DEF_WINDOW_ITEMS,
  parameter int WINDOW_SLOTS = wsr_pkg::DEF_WINDOW_SLOTS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode,
  input  logic [9:0]         end_index,
  input  logic [31:0]        end_position,
  input  logic [31:0]        position,
  input  logic signed [31:0] score,
  input  logic               valid_req,
  input  logic               cfg_we,
  input  logic [10:0]        cfg_wdata,
  output logic               result_valid,
  output logic [1:0]         status,
  output logic [9:0]         window_id,
  output logic [4:0]         item_index,
  output logic [5:0]         rank,
  output logic               rank_missing,
  output logic               last
);

  localparam int IW = $clog2(WINDOW_ITEMS);
  localparam int CW = $clog2(WINDOW_ITEMS + 1);
  localparam int AW = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int WW = $clog2(WINDOW_SLOTS + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_FI     = 3'd2;
  localparam logic [2:0] S_FCAP   = 3'd3;
  localparam logic [2:0] S_FSWEEP = 3'd4;
  localparam logic [2:0] S_TAIL   = 3'd5;

  logic [2:0]         state;
  logic [10:0]        window_count;
  logic               started;
  logic [CW-1:0]      count;
  logic [AW-1:0]      current_window;
  logic [31:0]        cur_end;
  logic [31:0]        pos_hold;
  logic signed [31:0] score_hold;
  logic               valid_hold;
  logic [WW-1:0]      w;
  logic [31:0]        found_end;
  logic               past;
  logic               finish_mode;
  logic [IW-1:0]      i;
  logic [IW-1:0]      j;
  logic signed [31:0] key_i;
  logic [CW-1:0]      rank_acc;

  logic               accept;
  logic               load_ok;
  logic               joins;
  logic [WW-1:0]      active_n;
  logic [WW-1:0]      start_w;
  logic               item_last;
  logic               inc;
  logic [CW-1:0]      rank_now;

  logic               t_we;
  logic [AW-1:0]      t_raddr;
  logic [31:0]        t_rdata;
  logic               s_we;
  logic [IW-1:0]      s_waddr;
  logic [32:0]        s_wdata;
  logic [IW-1:0]      s_raddr;
  logic [32:0]        s_rdata;

  assign busy = (state != S_IDLE);

  always_comb begin
    accept = start && !busy;
    load_ok = accept && (opcode == wsr_pkg::OP_LOAD) &&
              (32'(end_index) < 32'(WINDOW_SLOTS));
    joins = started && (position <= cur_end);
    if (32'(window_count) < 32'(WINDOW_SLOTS)) begin
      active_n = WW'(window_count);
    end else begin
      active_n = WW'(WINDOW_SLOTS);
    end
    start_w = started ? (WW'(current_window) + WW'(1)) : WW'(current_window);
    item_last = ((CW'(i) + CW'(1)) == count) && (finish_mode || !past);
    inc = s_rdata[32] && (($signed(s_rdata[31:0]) > key_i) ||
                          ((j < i) && ($signed(s_rdata[31:0]) == key_i)));
    rank_now = rank_acc + CW'(inc);
  end

  always_comb begin
    t_we = load_ok;
    t_raddr = AW'(w);
    s_we = 1'b0;
    s_waddr = IW'(count);
    s_wdata = {valid_req, score};
    s_raddr = i;
    unique case (state)
      S_IDLE: begin
        if (accept && opcode == wsr_pkg::OP_ITEM) begin
          if (joins) begin
            s_we = (count < CW'(WINDOW_ITEMS));
          end else begin
            t_raddr = AW'(start_w);
          end
        end
      end
      S_SCAN: begin
        t_raddr = AW'(w + WW'(1));
      end
      S_FI: begin
        s_raddr = i;
      end
      S_FCAP: begin
        s_raddr = '0;
      end
      S_FSWEEP: begin
        s_raddr = j + IW'(1);
      end
      S_TAIL: begin
        s_we = !past;
        s_waddr = '0;
        s_wdata = {valid_hold, score_hold};
      end
      default: begin
      end
    endcase
  end

  wsr_ram #(
    .WIDTH(32),
    .DEPTH(WINDOW_SLOTS)
  ) u_end_table (
    .clk  (clk),
    .we   (t_we),
    .waddr(AW'(end_index)),
    .wdata(end_position),
    .raddr(t_raddr),
    .rdata(t_rdata)
  );

  wsr_ram #(
    .WIDTH(33),
    .DEPTH(WINDOW_ITEMS)
  ) u_item_buf (
    .clk  (clk),
    .we   (s_we),
    .waddr(s_waddr),
    .wdata(s_wdata),
    .raddr(s_raddr),
    .rdata(s_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      window_count <= wsr_pkg::WINDOW_COUNT_RESET;
      started <= 1'b0;
      count <= '0;
      current_window <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_we) begin
        window_count <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (opcode)
              wsr_pkg::OP_LOAD: begin
                if (load_ok && started && 32'(end_index) == 32'(current_window)) begin
                  cur_end <= end_position;
                end
              end
              wsr_pkg::OP_ITEM: begin
                if (joins) begin
                  if (count >= CW'(WINDOW_ITEMS)) begin
                    result_valid <= 1'b1;
                    status <= wsr_pkg::ST_FULL;
                    window_id <= 10'(current_window);
                    item_index <= '0;
                    rank <= '0;
                    rank_missing <= 1'b1;
                    last <= 1'b1;
                  end else begin
                    count <= count + CW'(1);
                  end
                end else begin
                  pos_hold <= position;
                  score_hold <= score;
                  valid_hold <= valid_req;
                  finish_mode <= 1'b0;
                  w <= start_w;
                  i <= '0;
                  if (start_w >= active_n) begin
                    past <= 1'b1;
                    state <= started ? S_FI : S_TAIL;
                  end else begin
                    past <= 1'b0;
                    state <= S_SCAN;
                  end
                end
              end
              wsr_pkg::OP_FINISH: begin
                finish_mode <= 1'b1;
                past <= 1'b0;
                i <= '0;
                if (started) begin
                  state <= S_FI;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          if (pos_hold > t_rdata) begin
            if ((w + WW'(1)) >= active_n) begin
              past <= 1'b1;
              state <= started ? S_FI : S_TAIL;
            end else begin
              w <= w + WW'(1);
            end
          end else begin
            found_end <= t_rdata;
            past <= 1'b0;
            state <= started ? S_FI : S_TAIL;
          end
        end
        S_FI: begin
          state <= S_FCAP;
        end
        S_FCAP: begin
          key_i <= $signed(s_rdata[31:0]);
          if (!s_rdata[32]) begin
            result_valid <= 1'b1;
            status <= wsr_pkg::ST_RANK;
            window_id <= 10'(current_window);
            item_index <= 5'(i);
            rank <= '0;
            rank_missing <= 1'b1;
            last <= item_last;
            if ((CW'(i) + CW'(1)) == count) begin
              count <= '0;
              started <= 1'b0;
              state <= finish_mode ? S_IDLE : S_TAIL;
            end else begin
              i <= i + IW'(1);
              state <= S_FI;
            end
          end else begin
            rank_acc <= CW'(1);
            j <= '0;
            state <= S_FSWEEP;
          end
        end
        S_FSWEEP: begin
          if ((CW'(j) + CW'(1)) == count) begin
            result_valid <= 1'b1;
            status <= wsr_pkg::ST_RANK;
            window_id <= 10'(current_window);
            item_index <= 5'(i);
            rank <= 6'(rank_now);
            rank_missing <= 1'b0;
            last <= item_last;
            if ((CW'(i) + CW'(1)) == count) begin
              count <= '0;
              started <= 1'b0;
              state <= finish_mode ? S_IDLE : S_TAIL;
            end else begin
              i <= i + IW'(1);
              state <= S_FI;
            end
          end else begin
            j <= j + IW'(1);
            rank_acc <= rank_now;
          end
        end
        S_TAIL: begin
          if (past) begin
            result_valid <= 1'b1;
            status <= wsr_pkg::ST_PAST;
            window_id <= '0;
            item_index <= '0;
            rank <= '0;
            rank_missing <= 1'b1;
            last <= 1'b1;
          end else begin
            current_window <= AW'(w);
            started <= 1'b1;
            count <= CW'(1);
            cur_end <= found_end;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(WINDOW_ITEMS))
    else $error("item buffer count beyond depth");

  a_open_window_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && started) |-> (count != '0))
    else $error("open window holds no item");

  a_past_closes: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status == wsr_pkg::ST_PAST) |-> (!started && last))
    else $error("past-window beat with an open window or not last");

  a_sweep_rank: assert property (@(posedge clk) disable iff (rst)
    (state == S_FSWEEP) |-> (rank_acc <= count))
    else $error("rank exceeds buffered count");

endmodule

### verif/tb_windowed_score_ranker.sv
`timescale 1ns / 1ps

module tb_windowed_score_ranker;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int TAIL_CYCLES = 64;
  localparam int TABLE_ENTRIES = 64;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [31:0] POS_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] window;
    logic [4:0] index;
    logic [5:0] rank;
    logic       missing;
    logic       last;
  } rank_result_t;

  class rank_scoreboard;
    logic [31:0]        ends [wsr_pkg::DEF_WINDOW_SLOTS];
    logic signed [31:0] held_score [wsr_pkg::DEF_WINDOW_ITEMS];
    logic               held_valid [wsr_pkg::DEF_WINDOW_ITEMS];
    int unsigned        held_count;
    int unsigned        cur_win;
    bit                 win_open;
    logic [10:0]        win_count;
    rank_result_t       pending [$];
    int                 errors;
    int                 beats;
    int                 ranked;
    int                 dropped;
    int                 beyond;

    function new();
      held_count = 0;
      cur_win = 0;
      win_open = 1'b0;
      win_count = wsr_pkg::WINDOW_COUNT_RESET;
      errors = 0;
      beats = 0;
      ranked = 0;
      dropped = 0;
      beyond = 0;
    endfunction

    function int unsigned windows_in_use();
      return (win_count < wsr_pkg::DEF_WINDOW_SLOTS) ? int'(win_count)
                                                     : wsr_pkg::DEF_WINDOW_SLOTS;
    endfunction

    function void push(logic [1:0] st, int unsigned win, int unsigned idx,
                       int unsigned rk, logic miss);
      rank_result_t r;
      r.status = st;
      r.window = 10'(win);
      r.index = 5'(idx);
      r.rank = 6'(rk);
      r.missing = miss;
      r.last = 1'b0;
      pending.insert(pending.size(), r);
    endfunction

    // one result per held item, in arrival order
    function void close_window();
      int unsigned i, j, rk;
      if (!win_open)
        return;
      for (i = 0; i < held_count; i++) begin
        if (!held_valid[i]) begin
          push(wsr_pkg::ST_RANK, cur_win, i, 0, 1'b1);
        end else begin
          rk = 1;
          for (j = 0; j < held_count; j++)
            if (held_valid[j] && (held_score[j] > held_score[i] ||
                (j < i && held_score[j] == held_score[i])))
              rk++;
          push(wsr_pkg::ST_RANK, cur_win, i, rk, 1'b0);
        end
      end
      held_count = 0;
      win_open = 1'b0;
    endfunction

    function void note_beat(logic [1:0] op, logic [9:0] slot, logic [31:0] endp,
                            logic [31:0] pos, logic signed [31:0] sc, logic vld);
      int unsigned first, w;
      bit joins;
      first = pending.size();
      beats++;
      if (op == wsr_pkg::OP_LOAD) begin
        if (slot < wsr_pkg::DEF_WINDOW_SLOTS)
          ends[slot] = endp;
      end else if (op == wsr_pkg::OP_FINISH) begin
        close_window();
      end else if (op == wsr_pkg::OP_ITEM) begin
        joins = win_open && cur_win < wsr_pkg::DEF_WINDOW_SLOTS && pos <= ends[cur_win];
        if (joins) begin
          if (held_count >= wsr_pkg::DEF_WINDOW_ITEMS) begin
            push(wsr_pkg::ST_FULL, cur_win, 0, 0, 1'b1);
          end else begin
            held_score[held_count] = sc;
            held_valid[held_count] = vld;
            held_count++;
          end
        end else begin
          w = win_open ? cur_win + 1 : cur_win;
          while (w < windows_in_use() && pos > ends[w])
            w++;
          close_window();
          if (w >= windows_in_use()) begin
            push(wsr_pkg::ST_PAST, 0, 0, 0, 1'b1);
          end else begin
            cur_win = w;
            win_open = 1'b1;
            held_score[0] = sc;
            held_valid[0] = vld;
            held_count = 1;
          end
        end
      end
      if (pending.size() > first)
        pending[pending.size() - 1].last = 1'b1;
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] error: %s", $time, what);
    endtask

    task check_result(rank_result_t got);
      rank_result_t exp;
      if (pending.size() == 0) begin
        report($sformatf("result with nothing pending: status %0d window %0d index %0d",
                         got.status, got.window, got.index));
        return;
      end
      exp = pending.pop_front();
      case (got.status)
        wsr_pkg::ST_RANK: ranked++;
        wsr_pkg::ST_FULL: dropped++;
        default: beyond++;
      endcase
      if (got.status != exp.status)
        report($sformatf("status %0d, want %0d", got.status, exp.status));
      if (got.window != exp.window)
        report($sformatf("window %0d, want %0d", got.window, exp.window));
      if (got.index != exp.index)
        report($sformatf("item index %0d, want %0d", got.index, exp.index));
      if (got.rank != exp.rank)
        report($sformatf("rank %0d, want %0d (window %0d index %0d)",
                         got.rank, exp.rank, exp.window, exp.index));
      if (got.missing != exp.missing)
        report($sformatf("rank_missing %0b, want %0b", got.missing, exp.missing));
      if (got.last != exp.last)
        report($sformatf("last %0b, want %0b", got.last, exp.last));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         opcode;
  logic [9:0]         end_index;
  logic [31:0]        end_position;
  logic [31:0]        position;
  logic signed [31:0] score;
  logic               valid_req;
  logic               cfg_we;
  logic [10:0]        cfg_wdata;
  logic               result_valid;
  logic [1:0]         status;
  logic [9:0]         window_id;
  logic [4:0]         item_index;
  logic [5:0]         rank;
  logic               rank_missing;
  logic               last;

  rank_scoreboard sb = new();
  int gen_win;
  int sent;
  int cycle_count;
  int mid_count;
  bit idling;

  windowed_score_ranker u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .end_index    (end_index),
    .end_position (end_position),
    .position     (position),
    .score        (score),
    .valid_req    (valid_req),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .result_valid (result_valid),
    .status       (status),
    .window_id    (window_id),
    .item_index   (item_index),
    .rank         (rank),
    .rank_missing (rank_missing),
    .last         (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && result_valid)
      sb.check_result({status, window_id, item_index, rank, rank_missing, last});
  end

  function automatic logic signed [31:0] pick_score();
    if ($urandom_range(0, 1) == 0)
      return $urandom;
    case ($urandom_range(0, 3))
      0: return -32'sd256;
      1: return 32'sd0;
      2: return 32'sd256;
      default: return 32'sd384;
    endcase
  endfunction

  task automatic send_beat(input logic [1:0] op, input logic [9:0] slot,
                           input logic [31:0] endp, input logic [31:0] pos,
                           input logic signed [31:0] sc, input logic vld);
    int gap;
    gap = (idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    opcode = op;
    end_index = slot;
    end_position = endp;
    position = pos;
    score = sc;
    valid_req = vld;
    do @(posedge clk); while (busy);
    sb.note_beat(op, slot, endp, pos, sc, vld);
    if (op != OP_UNUSED)
      sent++;
  endtask

  task automatic send_item(input logic [31:0] pos, input logic signed [31:0] sc,
                           input logic vld);
    send_beat(wsr_pkg::OP_ITEM, 10'($urandom), $urandom, pos, sc, vld);
  endtask

  task automatic send_finish();
    send_beat(wsr_pkg::OP_FINISH, 10'($urandom), $urandom, $urandom, $urandom,
              1'($urandom_range(0, 1)));
  endtask

  task automatic send_load(input logic [9:0] slot, input logic [31:0] endp);
    send_beat(wsr_pkg::OP_LOAD, slot, endp, $urandom, $urandom, 1'($urandom_range(0, 1)));
  endtask

  task automatic wait_idle(input int settle);
    @(negedge clk);
    start = 1'b0;
    while (sb.pending.size() != 0 || busy)
      @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_count(input logic [10:0] value);
    wait_idle(4);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(posedge clk);
    sb.win_count = value;
    @(negedge clk);
    cfg_we = 1'b0;
    gen_win = sb.cur_win;
  endtask

  // ascending items that all fall in one window a little ahead of the last
  task automatic window_burst(input int n);
    int unsigned lim, target;
    logic [31:0] lo, hi, step, pos;
    int k;
    lim = sb.windows_in_use();
    if (lim > TABLE_ENTRIES)
      lim = TABLE_ENTRIES;
    if (sb.cur_win > gen_win)
      gen_win = sb.cur_win;
    target = gen_win + 1 +
             (($urandom_range(0, 9) == 0) ? $urandom_range(4, 40) : $urandom_range(0, 2));
    if (target >= lim)
      target = lim - 1;
    gen_win = target;
    lo = (target == 0) ? 32'd0 : sb.ends[target - 1] + 32'd1;
    hi = sb.ends[target];
    step = (hi - lo) / 32'(n);
    pos = lo;
    for (k = 0; k < n; k++) begin
      send_item(pos, pick_score(), $urandom_range(0, 7) != 0);
      pos = pos + $urandom_range(0, step);
    end
  endtask

  task automatic noise_beat();
    int unsigned lim;
    logic [31:0] top;
    lim = sb.windows_in_use();
    if (lim > TABLE_ENTRIES)
      lim = TABLE_ENTRIES;
    top = (lim > 0) ? sb.ends[lim - 1] : POS_MAX;
    case ($urandom_range(0, 5))
      0: send_beat(OP_UNUSED, 10'($urandom), $urandom, $urandom, $urandom,
                   1'($urandom_range(0, 1)));
      1: send_finish();
      2: send_item($urandom, $urandom, 1'($urandom_range(0, 1)));
      default: begin
        if (top != POS_MAX)
          send_item(top + 32'd1 + ($urandom % (POS_MAX - top)), pick_score(), 1'b1);
        else
          send_finish();
      end
    endcase
  endtask

  task automatic random_phase(input int budget, input bit quiet, input bit big_first);
    int goal, n;
    bit first;
    goal = sent + budget;
    first = big_first;
    while (sent < goal) begin
      idling = !quiet && ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 6) == 0)
        noise_beat();
      case ($urandom_range(0, 49))
        0, 1, 2, 3: n = $urandom_range(32, 35);
        5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15: n = $urandom_range(6, 16);
        default: n = $urandom_range(1, 5);
      endcase
      if (first)
        n = 34;
      first = 1'b0;
      window_burst(n);
      if ($urandom_range(0, 3) == 0)
        send_finish();
    end
    send_finish();
  endtask

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int i;
    rst = 1'b1;
    start = 1'b0;
    opcode = wsr_pkg::OP_LOAD;
    end_index = '0;
    end_position = '0;
    position = '0;
    score = '0;
    valid_req = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    sent = 0;
    gen_win = 0;
    idling = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // one window at the reset count: extremes, ties, a masked item, the end boundary
    send_load(10'd0, 32'd100);
    send_finish();
    send_beat(OP_UNUSED, 10'h3FF, POS_MAX, POS_MAX, -32'sd1, 1'b1);
    send_item(32'd0, 32'sh7FFF_FFFF, 1'b1);
    send_item(32'd40, 32'sh8000_0000, 1'b1);
    send_item(32'd50, 32'sd256, 1'b0);
    send_item(32'd60, 32'sd256, 1'b1);
    send_item(32'd70, 32'sd256, 1'b1);
    send_item(32'd100, 32'sd0, 1'b1);
    send_item(32'd101, 32'sd5, 1'b1);
    send_item(32'd200, 32'sd5, 1'b1);
    send_finish();
    send_item(32'd300, -32'sd7, 1'b0);
    send_item(32'd301, -32'sd7, 1'b1);
    send_finish();

    write_count(11'd0);
    send_item(32'd5, 32'sd1, 1'b1);
    send_finish();

    // ascending end table over the whole position range, the last end at the top
    for (i = 0; i < TABLE_ENTRIES; i++) begin
      idling = (i % 32) < 16;
      if (i == TABLE_ENTRIES - 1)
        send_load(10'(i), POS_MAX);
      else
        send_load(10'(i), (32'(i) << 26) | 32'($urandom_range(0, (1 << 26) - 1)));
    end

    mid_count = $urandom_range(16, 48);
    write_count(11'(mid_count));
    random_phase(25, 1'b0, 1'b0);

    write_count(11'd1024);
    random_phase(35, 1'b0, 1'b1);

    write_count(11'h7FF);
    idling = 1'b0;
    gen_win = $urandom_range(20, 40);
    random_phase(25, 1'b1, 1'b0);
    send_item(POS_MAX, pick_score(), 1'b1);
    send_finish();

    wait_idle(TAIL_CYCLES);
    $display("covered %0d beats over window counts 1, 0, %0d, 1024 and 2047",
             sb.beats, mid_count);
    $display("results: %0d ranks, %0d buffer-full drops, %0d past the last window",
             sb.ranked, sb.dropped, sb.beyond);
    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### files.f
rtl/wsr_pkg.sv
rtl/wsr_ram.sv
rtl/windowed_score_ranker.sv
verif/tb_windowed_score_ranker.sv
